// File: rtl/zobrist_board_hasher_defines.svh
// Assertion macros shared by the zobrist_board_hasher RTL.
// Depends on nothing; the asserting modules must have aclk and aresetn.
`ifndef ZOBRIST_BOARD_HASHER_DEFINES_SVH
`define ZOBRIST_BOARD_HASHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on aclk outside reset.
`define ZBH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("zobrist_board_hasher assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define ZBH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("zobrist_board_hasher assertion failed");

`else

`define ZBH_ASSERT_IMPL(label, ante, cons)
`define ZBH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/zbh_pkg.sv
// Types, constants and the generator step function for the Zobrist hasher.
// Depends on nothing; used by zbh_keygen and zobrist_board_hasher.
package zbh_pkg;

    localparam int KEY_W      = 64;
    localparam int CHUNK_W    = 16;
    localparam int GEN_W      = 32;
    localparam int EP_KEYS    = 8;
    localparam int CASTLE_KEYS = 16;
    localparam int AUX_DEPTH  = EP_KEYS + CASTLE_KEYS;
    localparam int AUX_AW     = 5;

    localparam logic [GEN_W-1:0] SEED_RESET = 32'h1D2C3A4F;

    // Destination codes for a freshly generated key.
    localparam logic [1:0] SEL_PS   = 2'd0;
    localparam logic [1:0] SEL_AUX  = 2'd1;
    localparam logic [1:0] SEL_SIDE = 2'd2;

    typedef logic [KEY_W-1:0] key_t;

    // Status and write request from the key generator to the key store.
    typedef struct packed {
        logic       busy;
        logic       wr_en;
        logic [1:0] wr_sel;
    } fill_ctl_t;

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic logic [GEN_W-1:0] xorshift32(input logic [GEN_W-1:0] x);
        logic [GEN_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

// File: rtl/zobrist_board_hasher.sv
// Zobrist position hasher. After reset, and after every write of the seed
// register, the key store is regenerated from the xorshift32 seed: one generator
// step per cycle and four steps per key, with s_ready low throughout. After that
// the block takes one square request per cycle while stage 1 is not stalled. The
// request marked last_square passes through the stage-1 registers and the output
// register onto the m_ channel; a stalled result holds back stage 1 and the input
// only when stage 1 holds another last square. Depends on zbh_pkg, zbh_keygen and
// the defines header.
`include "zobrist_board_hasher_defines.svh"

module zobrist_board_hasher #(
    parameter int SQUARE_COUNT = 64,
    parameter int PIECE_KINDS  = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [5:0]           s_square_index,
    input  logic [3:0]           s_piece_code,
    input  logic [3:0]           s_castling_rights,
    input  logic signed [3:0]    s_en_passant_file,
    input  logic                 s_black_to_move,
    input  logic                 s_last_square,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_position_hash
);
    import zbh_pkg::*;

    localparam int PS_COUNT = PIECE_KINDS * SQUARE_COUNT;
    localparam int PS_AW    = (PS_COUNT > 1) ? $clog2(PS_COUNT) : 1;

    fill_ctl_t         fill;
    logic [PS_AW-1:0]  wr_ps_addr;
    logic [AUX_AW-1:0] wr_aux_addr;
    key_t              wr_key;

    // Key stores: piece-square keys, en-passant and castling keys, then the side-to-move key.
    key_t key_mem [PS_COUNT];
    key_t aux_mem [AUX_DEPTH];
    key_t side_key_reg;

    key_t ps_rd_reg;
    key_t ep_rd_reg;
    key_t cs_rd_reg;

    logic              accept;
    logic              ps_hit;
    logic [PS_AW-1:0]  ps_addr;
    logic [AUX_AW-1:0] ep_addr;
    logic [AUX_AW-1:0] cs_addr;

    logic s1_valid_reg;
    logic s1_ps_hit_reg;
    logic s1_ep_hit_reg;
    logic s1_black_reg;
    logic s1_last_reg;
    logic s1_advance;
    logic s1_fire;

    key_t running_hash_reg;
    key_t hash_acc;
    key_t result;
    logic m_valid_reg;
    key_t m_hash_reg;

    zbh_keygen #(
        .PS_COUNT (PS_COUNT)
    ) u_keygen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fill        (fill),
        .wr_ps_addr  (wr_ps_addr),
        .wr_aux_addr (wr_aux_addr),
        .wr_key      (wr_key)
    );

    // Request decode and key addresses.
    assign ps_hit  = (int'(s_piece_code) < PIECE_KINDS) && (int'(s_square_index) < SQUARE_COUNT);
    assign ps_addr = PS_AW'(PS_AW'(s_piece_code) * PS_AW'(SQUARE_COUNT) + PS_AW'(s_square_index));
    assign ep_addr = {2'b00, s_en_passant_file[2:0]};
    assign cs_addr = AUX_AW'(EP_KEYS) + AUX_AW'(s_castling_rights);

    // Handshake: stage 1 stalls only when it holds the last square and the output is full and not taken.
    assign s1_advance = !(s1_valid_reg && s1_last_reg && m_valid_reg && !m_ready);
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign s_ready    = !fill.busy && s1_advance;
    assign accept     = s_valid && s_ready;

    // Key store writes from the generator.
    always_ff @(posedge aclk) begin
        if (fill.wr_en) begin
            unique case (fill.wr_sel)
                SEL_PS:   key_mem[wr_ps_addr] <= wr_key;
                SEL_AUX:  aux_mem[wr_aux_addr] <= wr_key;
                SEL_SIDE: side_key_reg <= wr_key;
                default:  ;
            endcase
        end
    end

    // Registered key reads, taken with the request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ps_rd_reg <= key_mem[ps_addr];
            ep_rd_reg <= aux_mem[ep_addr];
            cs_rd_reg <= aux_mem[cs_addr];
        end
    end

    // Stage 1 control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 flags travel with the read data.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ps_hit_reg <= ps_hit;
            s1_ep_hit_reg <= !s_en_passant_file[3];
            s1_black_reg  <= s_black_to_move;
            s1_last_reg   <= s_last_square;
        end
    end

    // Fold the square key in, and on the last square the position keys too.
    assign hash_acc = running_hash_reg ^ (s1_ps_hit_reg ? ps_rd_reg : '0);
    assign result   = hash_acc ^ cs_rd_reg
                    ^ (s1_ep_hit_reg ? ep_rd_reg : '0)
                    ^ (s1_black_reg ? side_key_reg : '0);

    // Running hash; cleared by reset, a seed write or a finished position.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            running_hash_reg <= '0;
        end else if (s1_fire) begin
            running_hash_reg <= s1_last_reg ? '0 : hash_acc;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_last_reg) begin
            m_hash_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_position_hash = m_hash_reg;

    `ZBH_ASSERT_NEXT(a_hash_cleared_after_last, s1_fire && s1_last_reg, running_hash_reg == '0)
    `ZBH_ASSERT_IMPL(a_stall_needs_full_output, s1_valid_reg && !s1_advance, m_valid_reg)
    `ZBH_ASSERT_NEXT(a_last_makes_result, s1_fire && s1_last_reg, m_valid_reg)

endmodule

// File: rtl/zbh_keygen.sv
// Key generator: runs xorshift32 and issues a 64-bit key write once four 16-bit chunks are assembled.
// Depends on zbh_pkg and zobrist_board_hasher_defines.svh.
`include "zobrist_board_hasher_defines.svh"

module zbh_keygen #(
    parameter int PS_COUNT = 768
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [31:0]                cfg_wr_data,
    output zbh_pkg::fill_ctl_t         fill,
    output logic [((PS_COUNT > 1) ? $clog2(PS_COUNT) : 1)-1:0] wr_ps_addr,
    output logic [zbh_pkg::AUX_AW-1:0] wr_aux_addr,
    output zbh_pkg::key_t              wr_key
);
    import zbh_pkg::*;

    localparam int PS_AW     = (PS_COUNT > 1) ? $clog2(PS_COUNT) : 1;
    localparam int KEY_COUNT = PS_COUNT + AUX_DEPTH + 1;
    localparam int KC_W      = $clog2(KEY_COUNT);
    localparam logic [1:0] LAST_CHUNK = 2'd3;

    logic [GEN_W-1:0]         gen_reg;
    logic [GEN_W-1:0]         gen_next;
    logic [1:0]               chunk_reg;
    logic [KC_W-1:0]          key_cnt_reg;
    logic [KEY_W-CHUNK_W-1:0] acc_reg;
    logic                     busy_reg;
    logic                     wr_en_reg;
    logic [1:0]               wr_sel_reg;
    logic [1:0]               sel_next;
    logic [KC_W-1:0]          aux_off;

    assign gen_next = xorshift32(gen_reg);
    assign aux_off  = key_cnt_reg - KC_W'(PS_COUNT);

    // Pick the store that receives the key being finished.
    always_comb begin
        if (key_cnt_reg < KC_W'(PS_COUNT)) begin
            sel_next = SEL_PS;
        end else if (key_cnt_reg < KC_W'(PS_COUNT + AUX_DEPTH)) begin
            sel_next = SEL_AUX;
        end else begin
            sel_next = SEL_SIDE;
        end
    end

    // Generator, chunk assembly and fill sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg     <= SEED_RESET;
            chunk_reg   <= '0;
            key_cnt_reg <= '0;
            busy_reg    <= 1'b1;
            wr_en_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            gen_reg     <= cfg_wr_data;
            chunk_reg   <= '0;
            key_cnt_reg <= '0;
            busy_reg    <= 1'b1;
            wr_en_reg   <= 1'b0;
        end else begin
            wr_en_reg <= busy_reg && (chunk_reg == LAST_CHUNK);
            if (busy_reg) begin
                gen_reg   <= gen_next;
                chunk_reg <= chunk_reg + 2'd1;
                if (chunk_reg == LAST_CHUNK) begin
                    if (key_cnt_reg == KC_W'(KEY_COUNT - 1)) begin
                        busy_reg <= 1'b0;
                    end else begin
                        key_cnt_reg <= key_cnt_reg + KC_W'(1);
                    end
                end
            end
        end
    end

    // Key payload and write address; no reset needed.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            unique case (chunk_reg)
                2'd0: acc_reg[15:0]  <= gen_next[CHUNK_W-1:0];
                2'd1: acc_reg[31:16] <= gen_next[CHUNK_W-1:0];
                2'd2: acc_reg[47:32] <= gen_next[CHUNK_W-1:0];
                default: begin
                    wr_key      <= {gen_next[CHUNK_W-1:0], acc_reg};
                    wr_sel_reg  <= sel_next;
                    wr_ps_addr  <= key_cnt_reg[PS_AW-1:0];
                    wr_aux_addr <= aux_off[AUX_AW-1:0];
                end
            endcase
        end
    end

    assign fill.busy   = busy_reg || wr_en_reg;
    assign fill.wr_en  = wr_en_reg;
    assign fill.wr_sel = wr_sel_reg;

    `ZBH_ASSERT_NEXT(a_cfg_restarts_fill, cfg_wr_en, busy_reg && key_cnt_reg == '0 && chunk_reg == '0)
    `ZBH_ASSERT_IMPL(a_count_in_range, busy_reg, key_cnt_reg < KC_W'(KEY_COUNT))
    `ZBH_ASSERT_IMPL(a_write_after_last_chunk, wr_en_reg, $past(chunk_reg) == LAST_CHUNK)

endmodule
